@@ rtl/core/slrpm_pkg.sv @@
// Shared types and constants for the source line risk pattern matcher.
package slrpm_pkg;

   // Window of newest line bytes seen by the compare logic, the incoming byte included
   localparam int WINDOW_BYTES = 11;
   localparam int BYTE_BITS    = 8;

   // Special byte codes
   localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [BYTE_BITS-1:0] NUL_BYTE     = 8'd0;

   // Full compare window, newest byte in the low byte lane
   typedef logic [WINDOW_BYTES*BYTE_BITS-1:0] win_type;

   // Stored history: the window without the incoming byte
   typedef logic [(WINDOW_BYTES-1)*BYTE_BITS-1:0] history_type;

   // One sticky flag per pattern group
   typedef struct packed {
      logic launch;
      logic str;
      logic mem;
   } hits_type;

endpackage

@@ rtl/core/slrpm_matcher.sv @@
// Parallel compare of the byte window against every call name and suffix pattern.
module slrpm_matcher (
   input  slrpm_pkg::win_type  win,
   output slrpm_pkg::hits_type hits
);
   import slrpm_pkg::*;

   localparam int NAME_COUNT   = 18;
   localparam int SUFFIX_COUNT = 4;
   localparam int TEXT_BYTES   = 8;

   typedef logic [TEXT_BYTES*BYTE_BITS-1:0] text_type;
   typedef logic [3:0] text_len_type;
   typedef enum logic [1:0] {
      GROUP_LAUNCH,
      GROUP_STRING,
      GROUP_MEMORY
   } group_type;

   // Call names, right aligned: last character in the low byte lane
   localparam text_type NAME_TEXT [NAME_COUNT] = '{
      "system", "popen", "exec", "execve", "execl", "execlp", "execle", "execv",
      "execvp", "execvpe", "gets", "strcpy", "strcat", "sprintf", "vsprintf",
      "memcpy", "memmove", "memset"
   };
   localparam text_len_type NAME_LEN [NAME_COUNT] = '{
      4'd6, 4'd5, 4'd4, 4'd6, 4'd5, 4'd6, 4'd6, 4'd5,
      4'd6, 4'd7, 4'd4, 4'd6, 4'd6, 4'd7, 4'd8,
      4'd6, 4'd7, 4'd6
   };
   localparam group_type NAME_GROUP [NAME_COUNT] = '{
      GROUP_LAUNCH, GROUP_LAUNCH, GROUP_LAUNCH, GROUP_LAUNCH, GROUP_LAUNCH,
      GROUP_LAUNCH, GROUP_LAUNCH, GROUP_LAUNCH, GROUP_LAUNCH, GROUP_LAUNCH,
      GROUP_STRING, GROUP_STRING, GROUP_STRING, GROUP_STRING, GROUP_STRING,
      GROUP_MEMORY, GROUP_MEMORY, GROUP_MEMORY
   };

   // Suffixes that follow a call name
   localparam text_type SUFFIX_TEXT [SUFFIX_COUNT] = '{"(", " (", "\t(", "\t ("};
   localparam text_len_type SUFFIX_LEN [SUFFIX_COUNT] = '{4'd1, 4'd2, 4'd2, 4'd3};

   // True when the text ends the window at the given distance from the newest byte
   function automatic logic tail_match(input win_type w, input text_type text,
                                       input text_len_type len, input int offset);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < TEXT_BYTES; i++) begin
         if ((i < int'(len)) &&
             (w[(offset + i)*BYTE_BITS +: BYTE_BITS] != text[i*BYTE_BITS +: BYTE_BITS])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Compare every suffix and name pair, fold hits per group
   always_comb begin
      logic sfx_ok;
      logic name_ok;
      hits = '0;
      for (int s = 0; s < SUFFIX_COUNT; s++) begin
         sfx_ok = tail_match(win, SUFFIX_TEXT[s], SUFFIX_LEN[s], 0);
         for (int k = 0; k < NAME_COUNT; k++) begin
            name_ok = sfx_ok && tail_match(win, NAME_TEXT[k], NAME_LEN[k], int'(SUFFIX_LEN[s]));
            case (NAME_GROUP[k])
               GROUP_LAUNCH: hits.launch = hits.launch | name_ok;
               GROUP_STRING: hits.str    = hits.str | name_ok;
               GROUP_MEMORY: hits.mem    = hits.mem | name_ok;
               default:      hits        = hits;
            endcase
         end
      end
   end

endmodule

@@ rtl/core/source_line_risk_pattern_matcher.sv @@
// Result: a beat that closes a line (newline or end of file) shows its result
//    on the rsp_ port in the cycle after acceptance, from the result register.
// Throughput: one req_ beat per cycle while the result register is free or being drained;
//    line state and the result register update together, but beats stall while a waiting result is not taken.
// Reset (synchronous, active high) clears the byte history, hit flags, NUL flag
//    and the result valid; the block accepts beats in the first cycle after reset.
module source_line_risk_pattern_matcher (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_text_byte,
   input  logic req_end_of_file,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_command_injection_hit,
   output logic rsp_buffer_overflow_hit,
   output logic rsp_memory_corruption_hit
);
   import slrpm_pkg::*;

   history_type history_ff, history_in;
   hits_type    seen_ff, seen_in;
   logic        past_nul_ff, past_nul_in;
   logic        rsp_valid_ff, rsp_valid_in;
   hits_type    rsp_hits_ff, rsp_hits_in;

   win_type  win;
   hits_type byte_hits;
   hits_type line_hits;
   logic     accept;
   logic     is_newline;
   logic     take;
   logic     close;

   // Compare window: stored history plus the incoming byte
   assign win = {history_ff, req_text_byte};

   slrpm_matcher u_matcher (
      .win  (win),
      .hits (byte_hits)
   );

   // Accept while the result register is free or being drained
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign is_newline = (req_text_byte == NEWLINE_BYTE);
   assign take       = !is_newline && (req_text_byte != NUL_BYTE) && !past_nul_ff;
   assign close      = is_newline || req_end_of_file;
   assign line_hits  = seen_ff | (take ? byte_hits : hits_type'('0));

   // Advance line state: shift in taken bytes, stick hits, note a NUL, clear at line end
   always_comb begin
      history_in  = history_ff;
      seen_in     = seen_ff;
      past_nul_in = past_nul_ff;
      if (accept) begin
         if (close) begin
            history_in  = '0;
            seen_in     = '0;
            past_nul_in = 1'b0;
         end else begin
            if (!is_newline && (req_text_byte == NUL_BYTE)) begin
               past_nul_in = 1'b1;
            end
            if (take) begin
               history_in = win[(WINDOW_BYTES-1)*BYTE_BITS-1:0];
               seen_in    = line_hits;
            end
         end
      end
   end

   // Load the result register on a closing beat, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hits_in  = rsp_hits_ff;
      if (accept && close) begin
         rsp_valid_in = 1'b1;
         rsp_hits_in  = line_hits;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff   <= '0;
         seen_ff      <= '0;
         past_nul_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         history_ff   <= history_in;
         seen_ff      <= seen_in;
         past_nul_ff  <= past_nul_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_hits_ff <= rsp_hits_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_command_injection_hit = rsp_hits_ff.launch;
   assign rsp_buffer_overflow_hit   = rsp_hits_ff.str;
   assign rsp_memory_corruption_hit = rsp_hits_ff.mem;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the source line risk pattern matcher.
`timescale 1ns / 100ps

module testbench;
   import slrpm_pkg::*;

   localparam int STALL_LIMIT   = 3000;
   localparam int RANDOM_BEATS  = 1700;
   localparam int HOLD_START    = 1200;
   localparam int HOLD_CYCLES   = 400;

   typedef struct {
      logic [BYTE_BITS-1:0] text;
      logic                 eof;
   } source_beat_type;

   // Line hit predictor and store of expected line results
   class line_scoreboard_type;
      string launch_calls[$] = '{"system", "popen", "exec", "execve", "execl", "execlp",
                                 "execle", "execv", "execvp", "execvpe"};
      string string_calls[$] = '{"gets", "strcpy", "strcat", "sprintf", "vsprintf"};
      string memory_calls[$] = '{"memcpy", "memmove", "memset"};
      string call_suffixes[$] = '{"(", " (", "\t(", "\t ("};

      logic [BYTE_BITS-1:0] history[WINDOW_BYTES-1];
      logic [BYTE_BITS-1:0] window[WINDOW_BYTES];
      hits_type             seen;
      bit                   past_nul;
      hits_type             line_hits[$];
      int unsigned          error_count;

      function new();
         error_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         foreach (history[i]) history[i] = '0;
         seen = '0;
         past_nul = 1'b0;
      endfunction

      // True when the window, cut off at stop, ends with pat
      function bit window_ends_with(int stop, string pat);
         int n;
         n = pat.len();
         if (n > stop) return 1'b0;
         for (int i = 0; i < n; i++)
            if (window[stop - n + i] != 8'(pat[i])) return 1'b0;
         return 1'b1;
      endfunction

      function bit any_call_ends(string calls[$], int stop);
         foreach (calls[k])
            if (window_ends_with(stop, calls[k])) return 1'b1;
         return 1'b0;
      endfunction

      // Shift one line byte in and flag any call pattern it completes
      function void take_byte(logic [BYTE_BITS-1:0] value);
         int stop;
         if (value == NUL_BYTE) past_nul = 1'b1;
         if (past_nul) return;
         for (int i = 0; i < WINDOW_BYTES - 1; i++) window[i] = history[i];
         window[WINDOW_BYTES-1] = value;
         foreach (call_suffixes[s]) begin
            if (!window_ends_with(WINDOW_BYTES, call_suffixes[s])) continue;
            stop = WINDOW_BYTES - call_suffixes[s].len();
            if (any_call_ends(launch_calls, stop)) seen.launch = 1'b1;
            if (any_call_ends(string_calls, stop)) seen.str = 1'b1;
            if (any_call_ends(memory_calls, stop)) seen.mem = 1'b1;
         end
         for (int i = 0; i < WINDOW_BYTES - 1; i++) history[i] = window[i+1];
      endfunction

      // Note an accepted input beat; queue a result when it closes the line
      function void note_beat(logic [BYTE_BITS-1:0] value, logic eof);
         if (value != NEWLINE_BYTE) take_byte(value);
         if (value == NEWLINE_BYTE || eof) begin
            line_hits.push_back(seen);
            clear_line();
         end
      endfunction

      // Compare an accepted result beat with the oldest expected line result
      function void check_result(hits_type got);
         hits_type want;
         if (line_hits.size() == 0) begin
            $error("result beat with no line result expected");
            error_count++;
            return;
         end
         want = line_hits.pop_front();
         if (got.launch !== want.launch) begin
            $error("command_injection_hit: expected %0b, actual %0b", want.launch, got.launch);
            error_count++;
         end
         if (got.str !== want.str) begin
            $error("buffer_overflow_hit: expected %0b, actual %0b", want.str, got.str);
            error_count++;
         end
         if (got.mem !== want.mem) begin
            $error("memory_corruption_hit: expected %0b, actual %0b", want.mem, got.mem);
            error_count++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_BITS-1:0] req_text_byte;
   logic                 req_end_of_file;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_command_injection_hit;
   logic                 rsp_buffer_overflow_hit;
   logic                 rsp_memory_corruption_hit;

   line_scoreboard_type board = new();
   source_beat_type     file_bytes[$];
   int unsigned         stalled_cycles = 0;

   source_line_risk_pattern_matcher uut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_text_byte             (req_text_byte),
      .req_end_of_file           (req_end_of_file),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_command_injection_hit (rsp_command_injection_hit),
      .rsp_buffer_overflow_hit   (rsp_buffer_overflow_hit),
      .rsp_memory_corruption_hit (rsp_memory_corruption_hit)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic push_byte(logic [BYTE_BITS-1:0] value, logic eof);
      file_bytes.push_back('{text: value, eof: eof});
   endtask

   task automatic push_text(string s, logic eof_on_last);
      for (int i = 0; i < s.len(); i++)
         push_byte(8'(s[i]), eof_on_last && (i == s.len() - 1));
   endtask

   function automatic string random_call();
      case ($urandom_range(0, 2))
         0: return board.launch_calls[$urandom_range(0, board.launch_calls.size() - 1)];
         1: return board.string_calls[$urandom_range(0, board.string_calls.size() - 1)];
         default: return board.memory_calls[$urandom_range(0, board.memory_calls.size() - 1)];
      endcase
   endfunction

   // Build one line: call patterns, near misses and filler, then a line end
   task automatic add_random_line();
      int    line_start;
      int    pick;
      string name;
      line_start = file_bytes.size();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
               push_text({random_call(), board.call_suffixes[$urandom_range(0, 3)]}, 1'b0);
            end else if (pick == 5) begin
               name = random_call();
               case ($urandom_range(0, 2))
                  0: push_text({name.substr(0, name.len() - 2),
                                board.call_suffixes[$urandom_range(0, 3)]}, 1'b0);
                  1: push_text({name, "  ("}, 1'b0);
                  default: push_text({name, "\t\t("}, 1'b0);
               endcase
            end else if (pick <= 8) begin
               repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(32, 126)), 1'b0);
            end else begin
               push_byte(($urandom_range(0, 3) == 0) ? NUL_BYTE : 8'($urandom_range(0, 255)),
                         1'b0);
            end
         end
      end
      // Close with a newline, a newline on end of file, or end of file on the last byte
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
         push_byte(NEWLINE_BYTE, 1'b0);
      end else if (pick < 94) begin
         push_byte(NEWLINE_BYTE, 1'b1);
      end else if (file_bytes.size() > line_start &&
                   file_bytes[file_bytes.size() - 1].text != NEWLINE_BYTE) begin
         file_bytes[file_bytes.size() - 1].eof = 1'b1;
      end else begin
         push_byte(8'($urandom_range(32, 126)), 1'b1);
      end
   endtask

   task automatic build_file();
      // Full window pattern closed by end of file, then an empty line
      push_text("vsprintf\t (", 1'b1);
      push_byte(NEWLINE_BYTE, 1'b0);
      // A hit before a NUL survives; a pattern after it is ignored
      push_text("exec(", 1'b0);
      push_byte(NUL_BYTE, 1'b0);
      push_text("gets(\n", 1'b0);
      // Top byte value as a one-byte file
      push_byte(8'hFF, 1'b1);
      while (file_bytes.size() < 25 + RANDOM_BEATS) add_random_line();
   endtask

   // Offer every byte of the file, idling now and then except in a steady stretch
   task automatic send_file();
      for (int idx = 0; idx < file_bytes.size(); idx++) begin
         while (!(idx >= 300 && idx < 700) && $urandom_range(0, 99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_text_byte <= file_bytes[idx].text;
         req_end_of_file <= file_bytes[idx].eof;
         do @(posedge clock); while (!req_ready);
         board.note_beat(file_bytes[idx].text, file_bytes[idx].eof);
      end
      req_valid <= 1'b0;
   endtask

   // Take result beats; stall at random, with a steady stretch and one long hold
   initial begin
      int unsigned cycle_count;
      int unsigned hold_left;
      hits_type    got;
      cycle_count = 0;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.launch = rsp_command_injection_hit;
            got.str = rsp_buffer_overflow_hit;
            got.mem = rsp_memory_corruption_hit;
            board.check_result(got);
         end
         cycle_count++;
         if (cycle_count == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (cycle_count >= 500 && cycle_count < 900) ||
                         ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // End the run when no beat moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == STALL_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_text_byte <= '0;
      req_end_of_file <= 1'b0;
      build_file();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_file();
      // Drain outstanding line results, then watch for stray beats
      while (board.line_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
